/* rtl/dd_pkg.sv */
// shared widths, constants and the month offset table for the day difference block
// no dependencies
package dd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DiffW  = 23;

  // absolute day number of a date, unsigned
  localparam int unsigned NumW   = 23;
  // day of year offset: month offset plus leap day plus day of month
  localparam int unsigned OfsW   = 9;
  // quotient of a year sum by one hundred
  localparam int unsigned QuotW  = 8;
  // year plus three hundred and ninety nine
  localparam int unsigned SumW   = 15;

  // floor(x / 100) = (x * Div100Mul) >> Div100Shift, exact for x below 43690
  localparam int unsigned Div100Shift = 22;
  localparam int unsigned Div100Mul   = 41944;
  localparam int unsigned ProdW       = 31;

  localparam logic signed [DiffW-1:0] DiffMax = {1'b0, {(DiffW-1){1'b1}}};
  localparam logic signed [DiffW-1:0] DiffMin = {1'b1, {(DiffW-1){1'b0}}};

  function automatic logic [OfsW-1:0] days_before_month(input logic [MonthW-1:0] m);
    logic [OfsW-1:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd334 + 9'd31;
    endcase
    return r;
  endfunction

endpackage

/* rtl/date_difference_days.sv */
// signed day difference between two gregorian dates, first minus other
// registered through dd_day_number and diff_q; one date pair per cycle unless stalled
// each stage holds under back pressure and keeps taking items while it has room
// reset clears only the stage valid bits; the data registers are not reset
// depends on dd_pkg and dd_day_number
module date_difference_days import dd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [YearW-1:0]        first_year_i,
  input  logic [MonthW-1:0]       first_month_i,
  input  logic [DayW-1:0]         first_day_i,
  input  logic [YearW-1:0]        other_year_i,
  input  logic [MonthW-1:0]       other_month_i,
  input  logic [DayW-1:0]         other_day_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DiffW-1:0] day_difference_o
);

  logic [3:0] valid_q, valid_d;
  logic [3:0] en;

  always_comb begin
    en[3] = !valid_q[3] || out_ready_i;
    en[2] = !valid_q[2] || en[3];
    en[1] = !valid_q[1] || en[2];
    en[0] = !valid_q[0] || en[1];
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    valid_d[1] = en[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = en[2] ? valid_q[1] : valid_q[2];
    valid_d[3] = en[3] ? valid_q[2] : valid_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  logic [NumW-1:0] first_num, other_num;

  dd_day_number u_first (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .year_i  (first_year_i),
    .month_i (first_month_i),
    .day_i   (first_day_i),
    .num_o   (first_num)
  );

  dd_day_number u_other (
    .clk_i   (clk_i),
    .en_i    (en[2:0]),
    .year_i  (other_year_i),
    .month_i (other_month_i),
    .day_i   (other_day_i),
    .num_o   (other_num)
  );

  // stage 4: subtract and saturate
  logic signed [NumW:0]    diff_w;
  logic signed [DiffW-1:0] diff_d, diff_q;

  always_comb begin
    diff_w = $signed({1'b0, first_num}) - $signed({1'b0, other_num});
    priority if (diff_w > (NumW+1)'(DiffMax)) begin
      diff_d = DiffMax;
    end else if (diff_w < $signed({DiffMin[DiffW-1], DiffMin})) begin
      diff_d = DiffMin;
    end else begin
      diff_d = diff_w[DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      diff_q <= diff_d;
    end
  end

  assign in_ready_o       = en[0];
  assign out_valid_o      = valid_q[3];
  assign day_difference_o = diff_q;

endmodule

/* rtl/dd_day_number.sv */
// three stage absolute day number of one gregorian date
// depends on dd_pkg; stage enables come from the top level
module dd_day_number import dd_pkg::*; (
  input  logic              clk_i,
  input  logic [2:0]        en_i,
  input  logic [YearW-1:0]  year_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output logic [NumW-1:0]   num_o
);

  // stage 1: quotients by one hundred
  logic [SumW-1:0]   sum_a, sum_b;
  logic [ProdW-1:0]  prod_a, prod_b;
  logic [QuotW-1:0]  qa_d, qa_q, qb_d, qb_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;

  assign sum_a  = SumW'(year_i) + SumW'(99);
  assign sum_b  = SumW'(year_i) + SumW'(399);
  assign prod_a = ProdW'(sum_a) * ProdW'(Div100Mul);
  assign prod_b = ProdW'(sum_b) * ProdW'(Div100Mul);
  assign qa_d   = prod_a[Div100Shift +: QuotW];
  assign qb_d   = prod_b[Div100Shift +: QuotW];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      qa_q    <= qa_d;
      qb_q    <= qb_d;
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
  end

  // stage 2: days of whole years and day of year
  logic [NumW:0]     y365, base_w;
  logic [YearW-1:0]  y_by4;
  logic [SumW-1:0]   qa_x100;
  logic              cent, leap;
  logic [NumW-1:0]   base_d, base_q;
  logic [OfsW-1:0]   ofs_d, ofs_q;

  always_comb begin
    y365 = (NumW+1)'(year_q) + ((NumW+1)'(year_q) << 2) + ((NumW+1)'(year_q) << 3)
         + ((NumW+1)'(year_q) << 5) + ((NumW+1)'(year_q) << 6)
         + ((NumW+1)'(year_q) << 8);
    y_by4   = YearW'(({1'b0, year_q} + (YearW+1)'(3)) >> 2);
    base_w  = y365 + (NumW+1)'(y_by4) - (NumW+1)'(qa_q) + (NumW+1)'(qb_q >> 2);
    base_d  = base_w[NumW-1:0];
    qa_x100 = (SumW'(qa_q) << 6) + (SumW'(qa_q) << 5) + (SumW'(qa_q) << 2);
    cent    = (qa_x100 == SumW'(year_q));
    leap    = (year_q[1:0] == 2'b00) && (!cent || (qa_q[1:0] == 2'b00));
    ofs_d   = days_before_month(month_q) + OfsW'(leap && (month_q >= 4'd3))
            + OfsW'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      base_q <= base_d;
      ofs_q  <= ofs_d;
    end
  end

  // stage 3: day number
  logic [NumW-1:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num_q <= base_q + NumW'(ofs_q);
    end
  end

  assign num_o = num_q;

endmodule

/* test/tb.sv */
// self-checking testbench for date_difference_days: directed and random date pairs
// with random gaps on both channels, results checked in order against a day count model
// depends on dd_pkg and the date_difference_days rtl
module tb import dd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  class DayDiffScoreboard;
    logic signed [DiffW-1:0] expected_diffs[$];
    int unsigned             fail_count = 0;

    static function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned months_before(int unsigned m);
      case (m)
        2:       return 31;
        3:       return 59;
        4:       return 90;
        5:       return 120;
        6:       return 151;
        7:       return 181;
        8:       return 212;
        9:       return 243;
        10:      return 273;
        11:      return 304;
        12:      return 334;
        13, 14, 15: return 365;
        default: return 0;
      endcase
    endfunction

    function int unsigned day_count(date_t dt);
      int unsigned y;
      int unsigned n;
      y = dt.year;
      n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      n += months_before(dt.month);
      if (dt.month >= 3 && is_leap(y)) begin
        n += 1;
      end
      n += dt.day;
      return n;
    endfunction

    function void note_pair(date_t first, date_t other);
      longint diff;
      diff = longint'(day_count(first)) - longint'(day_count(other));
      if (diff > longint'(DiffMax)) begin
        diff = longint'(DiffMax);
      end
      if (diff < longint'(DiffMin)) begin
        diff = longint'(DiffMin);
      end
      expected_diffs.push_back(diff[DiffW-1:0]);
    endfunction

    function void check_difference(logic signed [DiffW-1:0] got);
      logic signed [DiffW-1:0] want;
      if (expected_diffs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0d", $time, got);
        fail_count++;
        return;
      end
      want = expected_diffs.pop_front();
      if (got !== want) begin
        $display("%0t: day_difference mismatch, expected %0d actual %0d", $time, want, got);
        fail_count++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [YearW-1:0]        first_year_i = '0;
  logic [MonthW-1:0]       first_month_i = '0;
  logic [DayW-1:0]         first_day_i = '0;
  logic [YearW-1:0]        other_year_i = '0;
  logic [MonthW-1:0]       other_month_i = '0;
  logic [DayW-1:0]         other_day_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DiffW-1:0] day_difference_o;

  DayDiffScoreboard sb = new();
  bit               no_gaps = 1'b0;

  date_difference_days dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_year_i     (first_year_i),
    .first_month_i    (first_month_i),
    .first_day_i      (first_day_i),
    .other_year_i     (other_year_i),
    .other_month_i    (other_month_i),
    .other_day_i      (other_day_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .day_difference_o (day_difference_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic date_t mk(int unsigned y, int unsigned m, int unsigned d);
    date_t dt;
    dt.year  = y[YearW-1:0];
    dt.month = m[MonthW-1:0];
    dt.day   = d[DayW-1:0];
    return dt;
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    case (m)
      2:             return DayDiffScoreboard::is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic date_t random_date();
    int unsigned y;
    int unsigned m;
    y = $urandom_range(1000, 9999);
    m = $urandom_range(1, 12);
    return mk(y, m, $urandom_range(1, month_length(y, m)));
  endfunction

  function automatic date_t random_raw();
    date_t dt;
    dt.year  = YearW'($urandom());
    dt.month = MonthW'($urandom());
    dt.day   = DayW'($urandom());
    return dt;
  endfunction

  task automatic send_pair(date_t first, date_t other);
    while (!no_gaps && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    first_year_i  <= first.year;
    first_month_i <= first.month;
    first_day_i   <= first.day;
    other_year_i  <= other.year;
    other_month_i <= other.month;
    other_day_i   <= other.day;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_pair(first, other);
  endtask

  // result channel: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_difference(day_difference_o);
    end
    out_ready_i <= no_gaps || ($urandom_range(99) >= 34);
  end

  initial begin
    date_t a;
    date_t b;
    int    kind;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(mk(1000, 1, 1), mk(9999, 12, 31));
    send_pair(mk(9999, 12, 31), mk(1000, 1, 1));
    send_pair(mk(2024, 6, 15), mk(2024, 6, 15));
    send_pair(mk(2000, 2, 29), mk(2000, 3, 1));
    send_pair(mk(1900, 3, 1), mk(1900, 2, 28));
    send_pair(mk(2004, 3, 1), mk(2004, 2, 29));
    send_pair(mk(2100, 12, 31), mk(2100, 1, 1));
    send_pair(mk(2400, 12, 31), mk(2399, 12, 31));
    send_pair(mk(2023, 0, 5), mk(2023, 1, 5));
    send_pair(mk(2024, 13, 1), mk(2025, 1, 1));
    send_pair(mk(2023, 15, 31), mk(2023, 12, 31));
    send_pair(mk(2023, 2, 31), mk(2023, 3, 3));
    send_pair(mk(2023, 5, 0), mk(2023, 4, 30));
    send_pair(mk(0, 1, 1), mk(0, 3, 1));
    send_pair(mk(0, 0, 0), mk(0, 0, 0));
    send_pair(mk(16383, 15, 31), mk(0, 0, 0));
    send_pair(mk(0, 0, 0), mk(16383, 15, 31));
    send_pair(mk(16383, 12, 31), mk(5000, 1, 1));
    send_pair(mk(1000, 1, 1), mk(15000, 6, 1));
    send_pair(mk(12000, 2, 29), mk(12000, 2, 28));
    send_pair(mk(9999, 1, 1), mk(9998, 12, 31));
    send_pair(mk(1600, 2, 29), mk(1700, 2, 28));

    for (int i = 0; i < 450; i++) begin
      no_gaps = (i >= 150 && i < 250);
      kind = $urandom_range(99);
      if (kind < 60) begin
        a = random_date();
        b = random_date();
      end else if (kind < 80) begin
        a = random_date();
        b = random_date();
        b.year = YearW'(a.year + $urandom_range(0, 2) - 1);
      end else if (kind < 90) begin
        a = random_raw();
        b = random_raw();
      end else begin
        a = random_date();
        b = random_raw();
        if ($urandom_range(1)) begin
          b.year = a.year;
        end
      end
      send_pair(a, b);
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.expected_diffs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.expected_diffs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/dd_pkg.sv
rtl/dd_day_number.sv
rtl/date_difference_days.sv
test/tb.sv
